// ===== src/tsa_pkg.sv =====
// Shared constants and types for the timestamp arithmetic unit.
package tsa_pkg;

  // Request operation codes.
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_SUB    = 3'd1;
  localparam logic [2:0] OP_NEG    = 3'd2;
  localparam logic [2:0] OP_CMP    = 3'd3;
  localparam logic [2:0] OP_WITHIN = 3'd4;

  // Compare result codes.
  localparam logic [1:0] ORD_EQ = 2'd0;
  localparam logic [1:0] ORD_LT = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  // Configuration register indexes and port widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 63;
  localparam logic [CFG_IDX_W-1:0] REG_THR_SEC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_NSEC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_FRAC = 2'd2;

  // One second in nanoseconds, and two seconds, as wide signed constants.
  localparam logic signed [33:0] NS_PER_SEC   = 34'sd1000000000;
  localparam logic signed [33:0] NS_PER_SEC_2 = 34'sd2000000000;

  // Tolerance for the within-threshold test.
  typedef struct packed {
    logic [62:0] sec;
    logic [29:0] nsec;
    logic [31:0] frac;
  } threshold_t;

endpackage

// ===== src/timestamp_arithmetic_unit.sv =====
// Top level of the timestamp arithmetic unit: a ten-stage arithmetic pipeline.
//
// Usage:
// - Request channel (req_valid/req_ready) carries one word: an operation in
//   req_type and two timestamps A and B (seconds, nanoseconds, 2^-32 ns frac).
// - Result channel (res_valid/res_ready) returns exactly one word per request,
//   in request order: the normalized sum, difference or negation, the compare
//   code in order, or the within-threshold flag in within_res.
// - The tolerance registers are written through cfg_we/cfg_index/cfg_data and
//   must only change while no request is in flight.
// - The pipeline has ten register stages: the request capture and nine
//   working stages. Throughput is one word per cycle while res_ready holds;
//   the depth comes from the within test, which runs three chained
//   subtract/normalize passes, each split into a subtract, a quotient step and
//   a seconds adjust.
// - Reset (rst, synchronous) empties the pipeline and clears the tolerance.
// - When the receiver stalls, words stay in their stages; bubbles ahead of the
//   stall still close up, so the request side keeps accepting until every
//   stage is full.
module timestamp_arithmetic_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [2:0]                     req_type,
  input  logic signed [63:0]             a_sec,
  input  logic [29:0]                    a_nsec,
  input  logic [31:0]                    a_frac,
  input  logic signed [63:0]             b_sec,
  input  logic [29:0]                    b_nsec,
  input  logic [31:0]                    b_frac,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic signed [63:0]             res_sec,
  output logic [29:0]                    res_nsec,
  output logic [31:0]                    res_frac,
  output logic [1:0]                     order,
  output logic                           within_res,
  input  logic                           cfg_we,
  input  logic [tsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsa_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Captured request word.
  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] a_sec;
    logic [29:0] a_nsec;
    logic [31:0] a_frac;
    logic [63:0] b_sec;
    logic [29:0] b_nsec;
    logic [31:0] b_frac;
  } req_t;

  // Working timestamp carried down the pipeline, with a pending second carry.
  typedef struct packed {
    logic [2:0]         op;
    logic [63:0]        sec;
    logic signed [31:0] ns;
    logic [31:0]        frac;
    logic signed [2:0]  q;
    logic [1:0]         order;
    logic               in_tol;
  } work_t;

  tsa_pkg::threshold_t thr;
  req_t                req0;
  work_t               wrk [1:9];
  work_t               nxt [1:9];
  logic [9:0]          v;
  logic [9:0]          en;

  tsa_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .thr       (thr)
  );

  // Subtract B from A over the combined nanosecond and fraction value.
  function automatic work_t f_sub(work_t w, logic [63:0] as, logic [29:0] an,
                                  logic [31:0] af, logic [63:0] bs,
                                  logic [29:0] bn, logic [31:0] bf);
    work_t       r;
    logic [63:0] d;
    r      = w;
    d      = {2'b00, an, af} - {2'b00, bn, bf};
    r.sec  = as - bs;
    r.ns   = $signed(d[63:32]);
    r.frac = d[31:0];
    r.q    = 3'sd0;
    return r;
  endfunction

  // Floor-divide the nanosecond count by one second; keep the remainder.
  function automatic work_t f_norm(work_t w);
    work_t              r;
    logic signed [33:0] x;
    logic signed [33:0] m;
    r = w;
    x = 34'($signed(w.ns));
    if (x < -tsa_pkg::NS_PER_SEC) begin
      r.q = -3'sd2;
      m   = x + tsa_pkg::NS_PER_SEC_2;
    end else if (x < 34'sd0) begin
      r.q = -3'sd1;
      m   = x + tsa_pkg::NS_PER_SEC;
    end else if (x < tsa_pkg::NS_PER_SEC) begin
      r.q = 3'sd0;
      m   = x;
    end else if (x < tsa_pkg::NS_PER_SEC_2) begin
      r.q = 3'sd1;
      m   = x - tsa_pkg::NS_PER_SEC;
    end else begin
      r.q = 3'sd2;
      m   = x - tsa_pkg::NS_PER_SEC_2;
    end
    r.ns = $signed(m[31:0]);
    return r;
  endfunction

  // Fold the pending carry into the seconds.
  function automatic work_t f_adj(work_t w);
    work_t r;
    r     = w;
    r.sec = w.sec + {{61{w.q[2]}}, w.q};
    r.q   = 3'sd0;
    return r;
  endfunction

  // First stage: form the raw sum or difference, or the compare code.
  always_comb begin
    logic [63:0] s;
    nxt[1]    = '0;
    nxt[1].op = req0.op;
    s         = {2'b00, req0.a_nsec, req0.a_frac} + {2'b00, req0.b_nsec, req0.b_frac};
    case (req0.op) inside
      tsa_pkg::OP_ADD: begin
        nxt[1].sec  = req0.a_sec + req0.b_sec;
        nxt[1].ns   = $signed(s[63:32]);
        nxt[1].frac = s[31:0];
      end
      tsa_pkg::OP_SUB, tsa_pkg::OP_WITHIN: begin
        nxt[1] = f_sub(nxt[1], req0.a_sec, req0.a_nsec, req0.a_frac,
                       req0.b_sec, req0.b_nsec, req0.b_frac);
      end
      tsa_pkg::OP_NEG: begin
        nxt[1] = f_sub(nxt[1], 64'd0, 30'd0, 32'd0,
                       req0.a_sec, req0.a_nsec, req0.a_frac);
      end
      tsa_pkg::OP_CMP: begin
        if ({~req0.a_sec[63], req0.a_sec[62:0], req0.a_nsec, req0.a_frac} <
            {~req0.b_sec[63], req0.b_sec[62:0], req0.b_nsec, req0.b_frac}) begin
          nxt[1].order = tsa_pkg::ORD_LT;
        end else if ({req0.a_sec, req0.a_nsec, req0.a_frac} ==
                     {req0.b_sec, req0.b_nsec, req0.b_frac}) begin
          nxt[1].order = tsa_pkg::ORD_EQ;
        end else begin
          nxt[1].order = tsa_pkg::ORD_GT;
        end
      end
      default: ;
    endcase
  end

  // Middle stages: normalize, then for the within test take the magnitude
  // and subtract it from the tolerance, normalizing each time.
  always_comb begin
    nxt[2] = f_norm(wrk[1]);
    nxt[3] = f_adj(wrk[2]);
    nxt[4] = wrk[3];
    if (wrk[3].op == tsa_pkg::OP_WITHIN && wrk[3].sec[63]) begin
      nxt[4] = f_sub(wrk[3], 64'd0, 30'd0, 32'd0,
                     wrk[3].sec, wrk[3].ns[29:0], wrk[3].frac);
    end
    nxt[5] = f_norm(wrk[4]);
    nxt[6] = f_adj(wrk[5]);
    nxt[7] = wrk[6];
    if (wrk[6].op == tsa_pkg::OP_WITHIN) begin
      nxt[7] = f_sub(wrk[6], {1'b0, thr.sec}, thr.nsec, thr.frac,
                     wrk[6].sec, wrk[6].ns[29:0], wrk[6].frac);
    end
    nxt[8] = f_norm(wrk[7]);
  end

  // Last stage: final seconds adjust; the within test keeps only its flag.
  always_comb begin
    nxt[9] = f_adj(wrk[8]);
    if (wrk[8].op == tsa_pkg::OP_WITHIN) begin
      nxt[9].in_tol = ~nxt[9].sec[63];
      nxt[9].sec    = '0;
      nxt[9].ns     = '0;
      nxt[9].frac   = '0;
    end
  end

  // Per-stage advance: a stage loads when it is empty or its word moves on.
  always_comb begin
    en[9] = ~v[9] | res_ready;
    for (int k = 8; k >= 0; k--) begin
      en[k] = ~v[k] | en[k+1];
    end
  end

  assign req_ready = en[0];

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= req_valid;
      end
      for (int k = 1; k <= 9; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      req0 <= '{op: req_type, a_sec: a_sec, a_nsec: a_nsec, a_frac: a_frac,
                b_sec: b_sec, b_nsec: b_nsec, b_frac: b_frac};
    end
    for (int k = 1; k <= 9; k++) begin
      if (en[k]) begin
        wrk[k] <= nxt[k];
      end
    end
  end

  // Result port.
  assign res_valid  = v[9];
  assign res_sec    = $signed(wrk[9].sec);
  assign res_nsec   = wrk[9].ns[29:0];
  assign res_frac   = wrk[9].frac;
  assign order      = wrk[9].order;
  assign within_res = wrk[9].in_tol;

  // Normalized nanoseconds always stay below one second.
  a_nsec_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_nsec < tsa_pkg::NS_PER_SEC[29:0])
    else $error("result nanoseconds out of range");

  // Only a compare word carries a compare code, and never an unused one.
  a_order_op: assert property (@(posedge clk) disable iff (rst)
    res_valid && order != tsa_pkg::ORD_EQ |->
      wrk[9].op == tsa_pkg::OP_CMP && order != 2'd3)
    else $error("compare code on a non-compare word");

  // Only a within word raises the flag, and then its seconds and fraction are zero.
  a_within_op: assert property (@(posedge clk) disable iff (rst)
    res_valid && within_res |->
      wrk[9].op == tsa_pkg::OP_WITHIN && res_sec == 64'sd0 && res_frac == 32'd0)
    else $error("within flag on a wrong word");

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid && v == '0)
    else $error("pipeline not empty after reset");

endmodule

// ===== src/tsa_regs.sv =====
// Configuration registers holding the within-threshold tolerance.
module tsa_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsa_pkg::CFG_DATA_W-1:0]    cfg_data,
  output tsa_pkg::threshold_t               thr
);

  // Write decoder; indexes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsa_pkg::REG_THR_SEC:  thr.sec  <= cfg_data;
        tsa_pkg::REG_THR_NSEC: thr.nsec <= cfg_data[29:0];
        tsa_pkg::REG_THR_FRAC: thr.frac <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== bench/timestamp_arithmetic_unit_test.sv =====
// Self-checking testbench for the timestamp arithmetic unit.
module timestamp_arithmetic_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_WORDS = 340;
  localparam longint NANOS = 1000000000;
  localparam logic [2:0] OP_RESERVED_LO = 3'd5;
  localparam logic [2:0] OP_RESERVED_HI = 3'd7;
  localparam logic [63:0] SEC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SEC_MIN = 64'h8000_0000_0000_0000;
  localparam logic [29:0] NSEC_TOP = 30'd999999999;
  localparam logic [29:0] NSEC_RAW_MAX = 30'h3FFF_FFFF;
  localparam logic [31:0] FRAC_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [63:0] sec;
    logic [29:0] nsec;
    logic [31:0] frac;
  } stamp_t;

  typedef struct packed {
    logic [2:0] op;
    stamp_t     a;
    stamp_t     b;
  } request_t;

  typedef struct packed {
    stamp_t     value;
    logic [1:0] ord;
    logic       in_tol;
  } outcome_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           req_valid;
  logic                           req_ready;
  logic [2:0]                     req_type;
  logic signed [63:0]             a_sec;
  logic [29:0]                    a_nsec;
  logic [31:0]                    a_frac;
  logic signed [63:0]             b_sec;
  logic [29:0]                    b_nsec;
  logic [31:0]                    b_frac;
  logic                           res_valid;
  logic                           res_ready;
  logic signed [63:0]             res_sec;
  logic [29:0]                    res_nsec;
  logic [31:0]                    res_frac;
  logic [1:0]                     order;
  logic                           within_res;
  logic                           cfg_we;
  logic [tsa_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tsa_pkg::CFG_DATA_W-1:0] cfg_data;

  // Tolerance as last written, results still owed by the block, and run status.
  tsa_pkg::threshold_t tol;
  outcome_t            owed_results[$];
  int unsigned         fault_count;
  int unsigned         cycle_count;
  int unsigned         send_idle_pct;
  int unsigned         recv_stall_pct;
  int unsigned         hold_span;

  timestamp_arithmetic_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_type   (req_type),
    .a_sec      (a_sec),
    .a_nsec     (a_nsec),
    .a_frac     (a_frac),
    .b_sec      (b_sec),
    .b_nsec     (b_nsec),
    .b_frac     (b_frac),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_sec    (res_sec),
    .res_nsec   (res_nsec),
    .res_frac   (res_frac),
    .order      (order),
    .within_res (within_res),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic stamp_t make_stamp(logic [63:0] s, logic [29:0] n, logic [31:0] f);
    return '{sec: s, nsec: n, frac: f};
  endfunction

  // Move whole seconds out of a signed nanosecond count (floor division).
  function automatic stamp_t carry_seconds(logic [63:0] sec, longint ns, logic [31:0] frac);
    longint q;
    longint m;
    q = ns / NANOS;
    m = ns % NANOS;
    if (m < 0) begin
      m += NANOS;
      q -= 1;
    end
    return '{sec: sec + q, nsec: m[29:0], frac: frac};
  endfunction

  // Nanoseconds and fraction are summed as one fixed-point value.
  function automatic stamp_t add_stamps(stamp_t a, stamp_t b);
    logic [63:0] s;
    s = {2'b00, a.nsec, 32'h0} + {2'b00, b.nsec, 32'h0} + 64'(a.frac) + 64'(b.frac);
    return carry_seconds(a.sec + b.sec, longint'({32'h0, s[63:32]}), s[31:0]);
  endfunction

  // The borrow leaves a signed 32-bit nanosecond count in the upper half.
  function automatic stamp_t sub_stamps(stamp_t a, stamp_t b);
    logic [63:0] d;
    d = {2'b00, a.nsec, a.frac} - {2'b00, b.nsec, b.frac};
    return carry_seconds(a.sec - b.sec, longint'({{32{d[63]}}, d[63:32]}), d[31:0]);
  endfunction

  function automatic logic [1:0] order_of(stamp_t a, stamp_t b);
    if (a.sec != b.sec)
      return ($signed(a.sec) < $signed(b.sec)) ? tsa_pkg::ORD_LT : tsa_pkg::ORD_GT;
    if (a.nsec != b.nsec) return (a.nsec < b.nsec) ? tsa_pkg::ORD_LT : tsa_pkg::ORD_GT;
    if (a.frac != b.frac) return (a.frac < b.frac) ? tsa_pkg::ORD_LT : tsa_pkg::ORD_GT;
    return tsa_pkg::ORD_EQ;
  endfunction

  // Absolute difference against the tolerance; wrapped extremes are taken as they come.
  function automatic logic within_tolerance(stamp_t a, stamp_t b);
    stamp_t gap;
    gap = sub_stamps(a, b);
    if (gap.sec[63]) gap = sub_stamps('0, gap);
    gap = sub_stamps(make_stamp({1'b0, tol.sec}, tol.nsec, tol.frac), gap);
    return !gap.sec[63];
  endfunction

  function automatic outcome_t predict_outcome(request_t r);
    outcome_t o;
    o = '0;
    case (r.op)
      tsa_pkg::OP_ADD:    o.value = add_stamps(r.a, r.b);
      tsa_pkg::OP_SUB:    o.value = sub_stamps(r.a, r.b);
      tsa_pkg::OP_NEG:    o.value = sub_stamps('0, r.a);
      tsa_pkg::OP_CMP:    o.ord = order_of(r.a, r.b);
      tsa_pkg::OP_WITHIN: o.in_tol = within_tolerance(r.a, r.b);
      default:            o = '0;
    endcase
    return o;
  endfunction

  function automatic stamp_t random_stamp();
    stamp_t s;
    case ($urandom_range(9))
      0: s.sec = {$urandom, $urandom};
      1: s.sec = $urandom_range(1) ? SEC_MAX - $urandom_range(2) : SEC_MIN + $urandom_range(2);
      default: s.sec = longint'($urandom_range(2000)) - 1000;
    endcase
    case ($urandom_range(15))
      0: s.nsec = 30'($urandom);
      1: s.nsec = NSEC_TOP;
      2: s.nsec = '0;
      default: s.nsec = 30'($urandom_range(NSEC_TOP));
    endcase
    case ($urandom_range(7))
      0: s.frac = '0;
      1: s.frac = FRAC_MAX;
      default: s.frac = $urandom;
    endcase
    return s;
  endfunction

  // B mostly lands near A so that compare and tolerance results fall both ways.
  function automatic request_t random_request();
    request_t r;
    int unsigned pick;
    r.a = random_stamp();
    if ($urandom_range(9) < 6) begin
      r.b = r.a;
      r.b.sec = r.a.sec + $urandom_range(2) - 1;
      pick = $urandom_range(3);
      if (pick == 1) r.b.frac = r.a.frac + $urandom_range(4) - 2;
      else if (pick > 1) r.b.nsec = 30'($urandom_range(NSEC_TOP));
    end else begin
      r.b = random_stamp();
    end
    if ($urandom_range(19) == 0) r.op = 3'($urandom_range(OP_RESERVED_HI, OP_RESERVED_LO));
    else r.op = 3'($urandom_range(tsa_pkg::OP_WITHIN));
    return r;
  endfunction

  // Offer one word; valid stays high after acceptance until the next call decides.
  task automatic send_word(request_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_type <= r.op;
    a_sec <= r.a.sec;
    a_nsec <= r.a.nsec;
    a_frac <= r.a.frac;
    b_sec <= r.b.sec;
    b_nsec <= r.b.nsec;
    b_frac <= r.b.frac;
    do @(posedge clk); while (!req_ready);
    owed_results.push_back(predict_outcome(r));
  endtask

  task automatic ask(logic [2:0] op, stamp_t a, stamp_t b);
    send_word('{op: op, a: a, b: b});
  endtask

  task automatic run_random(int count);
    repeat (count) send_word(random_request());
  endtask

  // Stop offering and let the pipeline empty completely.
  task automatic pause_until_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [tsa_pkg::CFG_IDX_W-1:0] idx,
                                logic [tsa_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tsa_pkg::REG_THR_SEC:  tol.sec = data;
      tsa_pkg::REG_THR_NSEC: tol.nsec = data[29:0];
      tsa_pkg::REG_THR_FRAC: tol.frac = data[31:0];
      default:               tol = tol;
    endcase
  endtask

  task automatic set_tolerance(logic [62:0] s, logic [29:0] n, logic [31:0] f);
    write_register(tsa_pkg::REG_THR_SEC, s);
    write_register(tsa_pkg::REG_THR_NSEC, 63'(n));
    write_register(tsa_pkg::REG_THR_FRAC, 63'(f));
  endtask

  // Carries between fraction, nanoseconds and seconds, and seconds wrap.
  task automatic test_arithmetic_extremes();
    ask(tsa_pkg::OP_ADD, make_stamp(SEC_MAX, NSEC_TOP, FRAC_MAX),
        make_stamp(SEC_MAX, NSEC_TOP, FRAC_MAX));
    ask(tsa_pkg::OP_ADD, make_stamp(SEC_MIN, 0, 0), make_stamp(SEC_MIN, 0, 1));
    ask(tsa_pkg::OP_ADD, make_stamp(0, NSEC_TOP, FRAC_MAX), make_stamp(0, 0, 1));
    ask(tsa_pkg::OP_ADD, make_stamp('1, NSEC_RAW_MAX, FRAC_MAX),
        make_stamp(5, NSEC_RAW_MAX, FRAC_MAX));
    ask(tsa_pkg::OP_SUB, make_stamp(0, 0, 0), make_stamp(0, 0, 1));
    ask(tsa_pkg::OP_SUB, make_stamp(SEC_MIN, 0, 0), make_stamp(1, 0, 0));
    ask(tsa_pkg::OP_SUB, make_stamp(SEC_MAX, NSEC_RAW_MAX, 0), make_stamp('1, 0, FRAC_MAX));
    ask(tsa_pkg::OP_NEG, make_stamp(0, 0, 0), random_stamp());
    ask(tsa_pkg::OP_NEG, make_stamp(SEC_MIN, 0, 0), random_stamp());
    ask(tsa_pkg::OP_NEG, make_stamp(3, 0, 1), random_stamp());
    ask(tsa_pkg::OP_NEG, make_stamp(0, NSEC_RAW_MAX, FRAC_MAX), random_stamp());
  endtask

  // Ordering on each field, the zero tolerance after reset, and unused codes.
  task automatic test_compare_and_reserved();
    ask(tsa_pkg::OP_CMP, make_stamp(42, 7, 9), make_stamp(42, 7, 9));
    ask(tsa_pkg::OP_CMP, make_stamp('1, NSEC_TOP, FRAC_MAX), make_stamp(0, 0, 0));
    ask(tsa_pkg::OP_CMP, make_stamp(5, 10, 0), make_stamp(5, 9, FRAC_MAX));
    ask(tsa_pkg::OP_CMP, make_stamp(5, 10, 1), make_stamp(5, 10, 2));
    ask(tsa_pkg::OP_CMP, make_stamp(5, NSEC_RAW_MAX, 0), make_stamp(5, NSEC_TOP, FRAC_MAX));
    ask(tsa_pkg::OP_WITHIN, make_stamp(9, 3, 3), make_stamp(9, 3, 3));
    ask(tsa_pkg::OP_WITHIN, make_stamp(9, 3, 3), make_stamp(9, 3, 4));
    ask(tsa_pkg::OP_WITHIN, make_stamp(SEC_MIN, 0, 0), make_stamp(0, 0, 0));
    for (int code = OP_RESERVED_LO; code <= OP_RESERVED_HI; code++)
      ask(3'(code), random_stamp(), random_stamp());
  endtask

  // A difference exactly at the tolerance passes, one fraction step more fails.
  task automatic test_tolerance_boundary();
    pause_until_drained();
    set_tolerance(63'd1, 30'd250000000, 32'h8000_0000);
    ask(tsa_pkg::OP_WITHIN, make_stamp(5, 250000000, 32'h8000_0000), make_stamp(4, 0, 0));
    ask(tsa_pkg::OP_WITHIN, make_stamp(4, 0, 0), make_stamp(5, 250000000, 32'h8000_0001));
    ask(tsa_pkg::OP_WITHIN, make_stamp(4, 0, 0), make_stamp(5, 250000000, 32'h8000_0000));
  endtask

  // Random traffic under each idling pattern, with a fresh tolerance per phase.
  task automatic test_random_phases();
    pause_until_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_tolerance('0, '0, '0);
    run_random(RANDOM_WORDS);

    pause_until_drained();
    send_idle_pct = 79;
    recv_stall_pct = 0;
    set_tolerance('1, NSEC_RAW_MAX, FRAC_MAX);
    run_random(RANDOM_WORDS);

    pause_until_drained();
    send_idle_pct = 0;
    recv_stall_pct = 79;
    set_tolerance(63'd1, 30'd500000000, $urandom);
    run_random(RANDOM_WORDS);

    pause_until_drained();
    send_idle_pct = 11;
    recv_stall_pct = 11;
    set_tolerance(63'd0, 30'($urandom_range(NSEC_TOP)), $urandom);
    run_random(RANDOM_WORDS);
  endtask

  // Hold the result side off long enough that every stage fills and input stalls.
  task automatic test_backpressure();
    pause_until_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_span = 60;
    run_random(40);
    pause_until_drained();
    run_random(10);
  endtask

  // Result side: a long hold-off when requested, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_span > 0) begin
      res_ready <= 1'b0;
      hold_span--;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fault_count++;
    end
  endfunction

  // Compare each accepted result word with the oldest owed one.
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && res_valid && res_ready) begin
      if (owed_results.size() == 0) begin
        $display("%0t: result word with nothing owed, sec %0h", $time, res_sec);
        fault_count++;
      end else begin
        want = owed_results.pop_front();
        check_field("res_sec", want.value.sec, res_sec);
        check_field("res_nsec", 64'(want.value.nsec), 64'(res_nsec));
        check_field("res_frac", 64'(want.value.frac), 64'(res_frac));
        check_field("order", 64'(want.ord), 64'(order));
        check_field("within_res", 64'(want.in_tol), 64'(within_res));
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req_type = tsa_pkg::OP_ADD;
    a_sec = '0;
    a_nsec = '0;
    a_frac = '0;
    b_sec = '0;
    b_nsec = '0;
    b_frac = '0;
    res_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = tsa_pkg::REG_THR_SEC;
    cfg_data = '0;
    tol = '0;
    fault_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_span = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_arithmetic_extremes();
    test_compare_and_reserved();
    test_tolerance_boundary();
    test_random_phases();
    test_backpressure();

    pause_until_drained();
    if (fault_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
